FILE: hw/rtl/prot3d_pkg.sv
package prot3d_pkg;

  localparam int CordicIterDefault = 16;
  localparam int FracBitsDefault = 16;
  localparam int CordicIterMax = 32;

  localparam logic signed [31:0] Deg2RadQ32 = 32'sd74961321;
  localparam logic signed [35:0] CordicKQ30 = 36'sh026DD3B6A;
  localparam logic signed [35:0] TrigOne = 36'sd1073741824;
  localparam logic signed [35:0] TrigMinus = -36'sd1073741824;
  localparam logic signed [35:0] CoordLim = 36'sd8589934591;
  localparam logic signed [35:0] CoordLimNeg = -36'sd8589934591;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] angle_yz;
    logic signed [31:0] angle_xz;
    logic signed [31:0] angle_xy;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } out_item_t;

  // one angle's CORDIC state
  typedef struct packed {
    logic signed [35:0] x;
    logic signed [35:0] y;
    logic signed [35:0] z;
    logic               neg;
  } cordic_t;

  // item data carried along the cell row
  typedef struct packed {
    logic               valid;
    logic signed [35:0] vx;
    logic signed [35:0] vy;
    logic signed [35:0] vz;
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    cordic_t            c0;
    cordic_t            c1;
    cordic_t            c2;
  } cell_t;

  function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
    logic [31:0] t;
    case (i)
      5'd0: t = 32'h3243F6A8;  5'd1: t = 32'h1DAC6705;
      5'd2: t = 32'h0FADBAFC;  5'd3: t = 32'h07F56EA6;
      5'd4: t = 32'h03FEAB76;  5'd5: t = 32'h01FFD55B;
      5'd6: t = 32'h00FFFAAA;  5'd7: t = 32'h007FFF55;
      5'd8: t = 32'h003FFFEA;  5'd9: t = 32'h001FFFFD;
      5'd10: t = 32'h000FFFFF; 5'd11: t = 32'h0007FFFF;
      5'd12: t = 32'h0003FFFF; 5'd13: t = 32'h0001FFFF;
      5'd14: t = 32'h0000FFFF; 5'd15: t = 32'h00007FFF;
      5'd16: t = 32'h00003FFF; 5'd17: t = 32'h00001FFF;
      5'd18: t = 32'h00000FFF; 5'd19: t = 32'h000007FF;
      5'd20: t = 32'h000003FF; 5'd21: t = 32'h000001FF;
      5'd22: t = 32'h000000FF; 5'd23: t = 32'h0000007F;
      5'd24: t = 32'h0000003F; 5'd25: t = 32'h0000001F;
      5'd26: t = 32'h0000000F; 5'd27: t = 32'h00000008;
      5'd28: t = 32'h00000004; 5'd29: t = 32'h00000002;
      5'd30: t = 32'h00000001; default: t = 32'h00000000;
    endcase
    return $signed({4'b0, t});
  endfunction

  function automatic logic signed [35:0] clamp36(input logic signed [71:0] v,
                                                 input logic signed [35:0] lo,
                                                 input logic signed [35:0] hi);
    logic signed [35:0] r;
    if (v < 72'(lo)) r = lo;
    else if (v > 72'(hi)) r = hi;
    else r = v[35:0];
    return r;
  endfunction

endpackage

FILE: hw/rtl/point_rotate_about_origin_3d.sv
// channel | ports                      | handshake
// in      | start, busy, in_item       | taken when start && !busy
// out     | done, out_item             | one-cycle strobe, cannot stall
// One item per cycle; busy is always low. The pipeline runs angle reduction
// (quotient, fold, radian scale), the row of CORDIC cells, the trig fold,
// a multiply then a sum for each plane rotation, and the pivot add
// and saturate. Synchronous reset clears only the valid
// bits of the pipeline.
module point_rotate_about_origin_3d #(
  parameter int CORDIC_ITERATIONS = prot3d_pkg::CordicIterDefault,
  parameter int FRAC_BITS = prot3d_pkg::FracBitsDefault
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  prot3d_pkg::in_item_t  in_item,
  output logic                  done,
  output prot3d_pkg::out_item_t out_item
);
  localparam int N = CORDIC_ITERATIONS;

  prot3d_pkg::cell_t row [N+1];
  prot3d_pkg::cordic_t ini0, ini1, ini2;
  logic v0, v1, v2;
  logic signed [35:0] vx0, vy0, vz0, vx1, vy1, vz1, vx2, vy2, vz2;
  logic signed [31:0] ox0, oy0, oz0, ox1, oy1, oz1, ox2, oy2, oz2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    v0 <= start;
    v1 <= v0;
    v2 <= v1;
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end
    vx0 <= 36'(in_item.point_x) - 36'(in_item.origin_x);
    vy0 <= 36'(in_item.point_y) - 36'(in_item.origin_y);
    vz0 <= 36'(in_item.point_z) - 36'(in_item.origin_z);
    ox0 <= in_item.origin_x; oy0 <= in_item.origin_y; oz0 <= in_item.origin_z;
    vx1 <= vx0; vy1 <= vy0; vz1 <= vz0;
    ox1 <= ox0; oy1 <= oy0; oz1 <= oz0;
    vx2 <= vx1; vy2 <= vy1; vz2 <= vz1;
    ox2 <= ox1; oy2 <= oy1; oz2 <= oz1;
  end

  prot3d_reduce #(.FRAC_BITS(FRAC_BITS)) u_red0 (.clk, .angle(in_item.angle_xy), .init(ini0));
  prot3d_reduce #(.FRAC_BITS(FRAC_BITS)) u_red1 (.clk, .angle(in_item.angle_xz), .init(ini1));
  prot3d_reduce #(.FRAC_BITS(FRAC_BITS)) u_red2 (.clk, .angle(in_item.angle_yz), .init(ini2));

  always_comb begin
    row[0].valid = v2;
    row[0].vx = vx2; row[0].vy = vy2; row[0].vz = vz2;
    row[0].ox = ox2; row[0].oy = oy2; row[0].oz = oz2;
    row[0].c0 = ini0; row[0].c1 = ini1; row[0].c2 = ini2;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    prot3d_cell #(.STEP(g)) u_cell (.clk, .rst, .din(row[g]), .dout(row[g+1]));
  end

  // trig fold and clamp
  logic signed [35:0] c0, s0, c1, s1, c2, s2;
  logic vt;
  logic signed [35:0] tx, ty, tz;
  logic signed [31:0] tox, toy, toz;

  function automatic logic signed [35:0] fold(input logic signed [35:0] v,
                                              input logic n);
    logic signed [35:0] w;
    w = n ? -v : v;
    return prot3d_pkg::clamp36(72'(w), prot3d_pkg::TrigMinus, prot3d_pkg::TrigOne);
  endfunction

  always_ff @(posedge clk) begin
    vt <= row[N].valid;
    if (rst) vt <= 1'b0;
    c0 <= fold(row[N].c0.x, row[N].c0.neg);
    s0 <= fold(row[N].c0.y, row[N].c0.neg);
    c1 <= fold(row[N].c1.x, row[N].c1.neg);
    s1 <= -fold(row[N].c1.y, row[N].c1.neg);
    c2 <= fold(row[N].c2.x, row[N].c2.neg);
    s2 <= -fold(row[N].c2.y, row[N].c2.neg);
    tx <= row[N].vx; ty <= row[N].vy; tz <= row[N].vz;
    tox <= row[N].ox; toy <= row[N].oy; toz <= row[N].oz;
  end

  // plane 1: (x,y) by xy
  logic signed [35:0] p1x, p1y, p1z, d1z;
  logic signed [35:0] c1d [2], s1d [2], c2d [4], s2d [4];
  logic signed [31:0] o1x [6], o1y [6], o1z [6];
  logic vd [6];

  prot3d_plane u_p1 (.clk, .a(tx), .b(ty), .c(c0), .s(s0), .a_out(p1x), .b_out(p1y));

  always_ff @(posedge clk) begin
    d1z <= tz;
    p1z <= d1z;
    c1d[0] <= c1; c1d[1] <= c1d[0];
    s1d[0] <= s1; s1d[1] <= s1d[0];
    c2d[0] <= c2; s2d[0] <= s2;
    for (int i = 1; i < 4; i++) begin
      c2d[i] <= c2d[i-1];
      s2d[i] <= s2d[i-1];
    end
    vd[0] <= vt; o1x[0] <= tox; o1y[0] <= toy; o1z[0] <= toz;
    for (int i = 1; i < 6; i++) begin
      vd[i] <= vd[i-1];
      o1x[i] <= o1x[i-1]; o1y[i] <= o1y[i-1]; o1z[i] <= o1z[i-1];
    end
    if (rst) for (int i = 0; i < 6; i++) vd[i] <= 1'b0;
  end

  // plane 2: (x,z) by xz with negated sine
  logic signed [35:0] p2x, p2z, p2y, d2y;
  prot3d_plane u_p2 (.clk, .a(p1x), .b(p1z), .c(c1d[1]), .s(s1d[1]),
                     .a_out(p2x), .b_out(p2z));

  // plane 3: (y,z) by yz with negated sine
  logic signed [35:0] p3y, p3z, p3x, d3x;
  prot3d_plane u_p3 (.clk, .a(p2y), .b(p2z), .c(c2d[3]), .s(s2d[3]),
                     .a_out(p3y), .b_out(p3z));

  always_ff @(posedge clk) begin
    d2y <= p1y; p2y <= d2y;
    d3x <= p2x; p3x <= d3x;
  end

  function automatic logic signed [31:0] sat(input logic signed [31:0] o,
                                             input logic signed [35:0] v);
    logic signed [36:0] t;
    t = 37'(o) + 37'(v);
    if (t > 37'sd2147483647) return 32'sh7FFFFFFF;
    if (t < -37'sd2147483648) return 32'sh80000000;
    return t[31:0];
  endfunction

  always_ff @(posedge clk) begin
    done <= vd[5];
    if (rst) done <= 1'b0;
    out_item.out_x <= sat(o1x[5], p3x);
    out_item.out_y <= sat(o1y[5], p3y);
    out_item.out_z <= sat(o1z[5], p3z);
  end

`ifndef SYNTH
  a_busy_low: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy raised");
  a_done_after_rst: assert property (@(posedge clk) (!rst && $past(rst)) |-> !done)
    else $error("done right after reset");
  a_trig_range: assert property (@(posedge clk) disable iff (rst)
      vd[0] |-> (c1d[0] <= prot3d_pkg::TrigOne && c1d[0] >= prot3d_pkg::TrigMinus))
    else $error("cosine out of range");
`endif
endmodule

FILE: hw/rtl/prot3d_reduce.sv
// Angle fold and degree-to-radian scale: three register stages.
module prot3d_reduce #(
  parameter int FRAC_BITS = prot3d_pkg::FracBitsDefault
) (
  input  logic                 clk,
  input  logic signed [31:0]   angle,
  output prot3d_pkg::cordic_t  init
);
  localparam logic signed [33:0] Full = 34'sd360 <<< FRAC_BITS;
  localparam logic signed [33:0] Half = 34'sd180 <<< FRAC_BITS;
  localparam logic signed [33:0] Quarter = 34'sd90 <<< FRAC_BITS;
  // floor(2^32 / 360); the quotient estimate is low by at most one
  localparam logic [31:0] Recip = 32'((64'd1 << 32) / 64'd360);

  logic [31:0] mag;
  logic [63:0] qprod;
  logic [31:0] mag_r;
  logic [31:0] quo_r;
  logic sgn_r;
  logic signed [33:0] rem;
  logic signed [33:0] a;
  logic signed [33:0] a_fold;
  logic neg;
  logic signed [33:0] a_r;
  logic neg_r;
  logic signed [67:0] rad;

  always_comb begin
    mag = angle[31] ? 32'(-angle) : angle;
    qprod = 64'(mag) * 64'(Recip);
  end

  always_ff @(posedge clk) begin
    mag_r <= mag;
    quo_r <= 32'(qprod >> (32 + FRAC_BITS));
    sgn_r <= angle[31];
  end

  always_comb begin
    rem = 34'(mag_r) - 34'(64'(quo_r) * 64'(Full));
    if (rem >= Full) rem = rem - Full;
    a = sgn_r ? -rem : rem;
    if (a < 0) a = a + Full;
    if (a > Half) a = a - Full;
    neg = 1'b0;
    a_fold = a;
    if (a > Quarter) begin
      a_fold = a - Half;
      neg = 1'b1;
    end else if (a < -Quarter) begin
      a_fold = a + Half;
      neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_fold;
    neg_r <= neg;
  end

  assign rad = 68'(a_r) * 68'(prot3d_pkg::Deg2RadQ32);

  always_ff @(posedge clk) begin
    init.x <= prot3d_pkg::CordicKQ30;
    init.y <= '0;
    init.z <= 36'(rad >>> (FRAC_BITS + 2));
    init.neg <= neg_r;
  end
endmodule

FILE: hw/rtl/prot3d_cell.sv
// One CORDIC iteration for the three angles; vector data rides along.
module prot3d_cell #(
  parameter int STEP = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  prot3d_pkg::cell_t   din,
  output prot3d_pkg::cell_t   dout
);
  localparam logic [4:0] Sh = 5'(STEP);

  function automatic prot3d_pkg::cordic_t iter(input prot3d_pkg::cordic_t c);
    prot3d_pkg::cordic_t r;
    logic signed [35:0] at;
    at = prot3d_pkg::atan_q30(Sh);
    r = c;
    if (!c.z[35]) begin
      r.x = c.x - (c.y >>> Sh);
      r.y = c.y + (c.x >>> Sh);
      r.z = c.z - at;
    end else begin
      r.x = c.x + (c.y >>> Sh);
      r.y = c.y - (c.x >>> Sh);
      r.z = c.z + at;
    end
    return r;
  endfunction

  prot3d_pkg::cell_t nxt;

  always_comb begin
    nxt = din;
    nxt.c0 = iter(din.c0);
    nxt.c1 = iter(din.c1);
    nxt.c2 = iter(din.c2);
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
    if (rst) dout.valid <= 1'b0;
  end
endmodule

FILE: hw/rtl/prot3d_plane.sv
// Plane rotation a' = a*c - b*s, b' = a*s + b*c; products then sums.
module prot3d_plane (
  input  logic               clk,
  input  logic signed [35:0] a,
  input  logic signed [35:0] b,
  input  logic signed [35:0] c,
  input  logic signed [35:0] s,
  output logic signed [35:0] a_out,
  output logic signed [35:0] b_out
);
  localparam logic signed [71:0] Half = 72'sd1 <<< 29;
  logic signed [71:0] ac, bs, as_, bc;
  logic signed [71:0] na, nb;

  always_ff @(posedge clk) begin
    ac <= 72'(a) * 72'(c);
    bs <= 72'(b) * 72'(s);
    as_ <= 72'(a) * 72'(s);
    bc <= 72'(b) * 72'(c);
  end

  always_comb begin
    na = ((ac + Half) >>> 30) - ((bs + Half) >>> 30);
    nb = ((as_ + Half) >>> 30) + ((bc + Half) >>> 30);
  end

  always_ff @(posedge clk) begin
    a_out <= prot3d_pkg::clamp36(na, prot3d_pkg::CoordLimNeg, prot3d_pkg::CoordLim);
    b_out <= prot3d_pkg::clamp36(nb, prot3d_pkg::CoordLimNeg, prot3d_pkg::CoordLim);
  end
endmodule
